### rtl/tournament_local_perceptron_predictor_core_assert.svh
// ----------------------------------------------------------------------------
// tournament predictor assertion macros
// shared concurrent assertion forms for the predictor checkers
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_LOCAL_PERCEPTRON_PREDICTOR_CORE_ASSERT_SVH
`define TOURNAMENT_LOCAL_PERCEPTRON_PREDICTOR_CORE_ASSERT_SVH

// plain property, checked outside reset
`define TLPP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tlpp assertion failed");

// condition implies expression on the next edge
`define TLPP_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("tlpp assertion failed");

`endif

### rtl/tlpp_pkg.sv
// ----------------------------------------------------------------------------
// tlpp_pkg
// shared types, defaults and counter helpers of the tournament predictor
// ----------------------------------------------------------------------------
package tlpp_pkg;

   localparam int LOCAL_BITS_DEF          = 10;
   localparam int CHOOSER_BITS_DEF        = 16;
   localparam int PERCEPTRON_ROW_BITS_DEF = 10;
   localparam int HISTORY_LEN_DEF         = 64;
   localparam int WEIGHT_BITS_DEF         = 8;

   localparam int THR_BITS = 7;
   localparam logic [THR_BITS-1:0] THR_RESET = 7'd32;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_MIN          = 2'd0;
   localparam ctr_type CTR_MAX          = 2'd3;
   localparam ctr_type CTR_WEAK_TAKEN   = 2'd2;
   localparam ctr_type CTR_STRONG_GLOBAL = 2'd0;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN   = 1'b1;

   function automatic ctr_type ctr_step(ctr_type c, logic up);
      ctr_type r;
      r = c;
      if (up && c != CTR_MAX) r = c + 2'd1;
      if (!up && c != CTR_MIN) r = c - 2'd1;
      return r;
   endfunction

endpackage

### rtl/tournament_local_perceptron_predictor_core.sv
// ----------------------------------------------------------------------------
// tournament_local_perceptron_predictor_core
// local two-level predictor and global perceptron picked by a chooser
// ----------------------------------------------------------------------------
// One branch transaction is handled at a time. After the acceptance edge,
// which also does the history, chooser and weight-row reads, the state
// S_RD1 does the dependent local counter read (with partial sums of the
// weights registered), and the state S_RD2 finishes the perceptron sum,
// loads the result register and, for a training transaction, writes the
// tables back (the chooser only when the two components disagree). A
// stalled response channel holds S_RD2. The next transaction can be
// accepted on the following edge; no new transaction is taken before the
// current one is through. The dependent counter read behind the local
// history read limits throughput. A result waiting in the output register
// does not block acceptance; only completion of the next transaction waits
// for it. After reset a clearing pass walks every address of the tables,
// during which no transaction is accepted; the threshold
// register may be written at any time the block is idle.
module tournament_local_perceptron_predictor_core #(
   parameter int LOCAL_BITS          = tlpp_pkg::LOCAL_BITS_DEF,
   parameter int CHOOSER_BITS        = tlpp_pkg::CHOOSER_BITS_DEF,
   parameter int PERCEPTRON_ROW_BITS = tlpp_pkg::PERCEPTRON_ROW_BITS_DEF,
   parameter int HISTORY_LEN         = tlpp_pkg::HISTORY_LEN_DEF,
   parameter int WEIGHT_BITS         = tlpp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // branch_pc[31:0], taken[32], zero pad
   input  logic                          req_tuser,  // operation
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // predict_taken[0], zero pad
   // threshold register
   input  logic                          csr_wen,
   input  logic [tlpp_pkg::THR_BITS-1:0] csr_wdata
);
   import tlpp_pkg::*;

   localparam int ROW_W  = HISTORY_LEN * WEIGHT_BITS;
   localparam int NGRP   = (HISTORY_LEN + 7) / 8;
   localparam int PW     = WEIGHT_BITS + 3;
   localparam int SW     = WEIGHT_BITS + $clog2(HISTORY_LEN) + 1;
   localparam int MAX_LR = (LOCAL_BITS > PERCEPTRON_ROW_BITS) ? LOCAL_BITS
                                                               : PERCEPTRON_ROW_BITS;
   localparam int CLR_BITS = (MAX_LR > CHOOSER_BITS) ? MAX_LR : CHOOSER_BITS;
   localparam logic signed [WEIGHT_BITS-1:0] WMAX = (WEIGHT_BITS)'((1 << (WEIGHT_BITS-1)) - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_RD1   = 2'd2;
   localparam logic [1:0] S_RD2   = 2'd3;

   // control
   logic [1:0]                 state_ff, state_in;
   logic [CLR_BITS-1:0]        clr_ff;
   logic [THR_BITS-1:0]        thr_ff;
   logic [HISTORY_LEN-1:0]     ghist_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_pred_ff;

   // captured transaction
   logic                       op_ff;
   logic                       taken_ff;
   logic [31:0]                pc_ff;

   // memories and their read registers
   logic [LOCAL_BITS-1:0]      lht_mem_ff  [2**LOCAL_BITS];
   ctr_type                    lcnt_mem_ff [2**LOCAL_BITS];
   ctr_type                    cho_mem_ff  [2**CHOOSER_BITS];
   logic [ROW_W-1:0]           wgt_mem_ff  [2**PERCEPTRON_ROW_BITS];
   logic [LOCAL_BITS-1:0]      lht_rd_ff;
   ctr_type                    lcnt_rd_ff;
   ctr_type                    cho_rd_ff;
   logic [ROW_W-1:0]           wgt_rd_ff;

   logic signed [PW-1:0]       part_ff [NGRP];
   logic signed [PW-1:0]       part_in [NGRP];

   logic                       accept;
   logic                       slot_free;
   logic                       finish;
   logic                       upd;
   logic                       clearing;
   logic signed [SW-1:0]       ysum;
   logic signed [SW-1:0]       thr_s;
   logic                       loc_guess, glob_guess, use_local, pred;
   logic                       train_w;
   logic [CHOOSER_BITS-1:0]    cidx;
   logic [ROW_W-1:0]           wgt_new;

   logic                       lht_we,  lcnt_we, cho_we, wgt_we;
   logic [LOCAL_BITS-1:0]      lht_wa,  lcnt_wa;
   logic [CHOOSER_BITS-1:0]    cho_wa;
   logic [PERCEPTRON_ROW_BITS-1:0] wgt_wa;
   logic [LOCAL_BITS-1:0]      lht_wd;
   ctr_type                    lcnt_wd, cho_wd;
   logic [ROW_W-1:0]           wgt_wd;

   assign clearing   = (state_ff == S_CLEAR);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == S_RD2) && slot_free;
   assign upd        = finish && (op_ff == OP_TRAIN);
   assign cidx       = CHOOSER_BITS'(ghist_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pred_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_RD1;
         end
         S_RD1: begin
            state_in = S_RD2;
         end
         S_RD2: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         thr_ff       <= THR_RESET;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (csr_wen) thr_ff <= csr_wdata;
         if (upd) ghist_ff <= {ghist_ff[HISTORY_LEN-2:0], taken_ff};
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // transaction payload and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tuser;
         pc_ff    <= req_tdata[31:0];
         taken_ff <= req_tdata[32];
      end
      if (finish) rsp_pred_ff <= pred;
      if (state_ff == S_RD1) part_ff <= part_in;
   end

   // partial sums of the selected weights, eight per group
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            if (g * 8 + k < HISTORY_LEN) begin
               if (ghist_ff[HISTORY_LEN-1-(g*8+k)]) begin
                  part_in[g] = part_in[g] + PW'($signed(wgt_rd_ff[(g*8+k)*WEIGHT_BITS +:
                                                                  WEIGHT_BITS]));
               end
            end
         end
      end
   end

   // final sum, predictions and weight update
   always_comb begin
      ysum = '0;
      for (int g = 0; g < NGRP; g++) ysum = ysum + SW'(part_ff[g]);
      thr_s       = SW'($signed({1'b0, thr_ff}));
      loc_guess   = (lcnt_rd_ff >= CTR_WEAK_TAKEN);
      glob_guess  = (ysum > 0);
      use_local   = (cho_rd_ff >= CTR_WEAK_TAKEN);
      pred        = use_local ? loc_guess : glob_guess;
      // wrong sign (zero counts as taken side) or weak magnitude
      train_w     = ((ysum < 0) == taken_ff) || ((ysum < thr_s) && (ysum > -thr_s));
      wgt_new     = wgt_rd_ff;
      for (int j = 0; j < HISTORY_LEN; j++) begin
         if (train_w && ghist_ff[HISTORY_LEN-1-j]) begin
            if (taken_ff) begin
               if ($signed(wgt_rd_ff[j*WEIGHT_BITS +: WEIGHT_BITS]) < WMAX)
                  wgt_new[j*WEIGHT_BITS +: WEIGHT_BITS] =
                     wgt_rd_ff[j*WEIGHT_BITS +: WEIGHT_BITS] + 1'b1;
            end else begin
               if ($signed(wgt_rd_ff[j*WEIGHT_BITS +: WEIGHT_BITS]) > -WMAX)
                  wgt_new[j*WEIGHT_BITS +: WEIGHT_BITS] =
                     wgt_rd_ff[j*WEIGHT_BITS +: WEIGHT_BITS] - 1'b1;
            end
         end
      end
   end

   // write ports: clearing pass or write-back of a training transaction
   always_comb begin
      lht_we  = clearing || upd;
      lcnt_we = clearing || upd;
      wgt_we  = clearing || upd;
      cho_we  = clearing || (upd && (loc_guess != glob_guess));
      if (clearing) begin
         lht_wa  = clr_ff[LOCAL_BITS-1:0];
         lcnt_wa = clr_ff[LOCAL_BITS-1:0];
         cho_wa  = clr_ff[CHOOSER_BITS-1:0];
         wgt_wa  = clr_ff[PERCEPTRON_ROW_BITS-1:0];
         lht_wd  = '0;
         lcnt_wd = CTR_WEAK_TAKEN;
         cho_wd  = CTR_STRONG_GLOBAL;
         wgt_wd  = '0;
      end else begin
         lht_wa  = pc_ff[LOCAL_BITS-1:0];
         lcnt_wa = lht_rd_ff;
         cho_wa  = cidx;
         wgt_wa  = pc_ff[PERCEPTRON_ROW_BITS-1:0];
         lht_wd  = {lht_rd_ff[LOCAL_BITS-2:0], taken_ff};
         lcnt_wd = ctr_step(lcnt_rd_ff, taken_ff);
         // exactly one component right: move toward it
         cho_wd  = ctr_step(cho_rd_ff, loc_guess == taken_ff);
         wgt_wd  = wgt_new;
      end
   end

   // local history table
   always_ff @(posedge clock) begin
      if (lht_we) lht_mem_ff[lht_wa] <= lht_wd;
      if (accept) lht_rd_ff <= lht_mem_ff[req_tdata[LOCAL_BITS-1:0]];
   end

   // local counters, addressed by the local history
   always_ff @(posedge clock) begin
      if (lcnt_we) lcnt_mem_ff[lcnt_wa] <= lcnt_wd;
      if (state_ff == S_RD1) lcnt_rd_ff <= lcnt_mem_ff[lht_rd_ff];
   end

   // chooser counters, addressed by the global history
   always_ff @(posedge clock) begin
      if (cho_we) cho_mem_ff[cho_wa] <= cho_wd;
      if (accept) cho_rd_ff <= cho_mem_ff[cidx];
   end

   // perceptron weight rows
   always_ff @(posedge clock) begin
      if (wgt_we) wgt_mem_ff[wgt_wa] <= wgt_wd;
      if (accept) wgt_rd_ff <= wgt_mem_ff[req_tdata[PERCEPTRON_ROW_BITS-1:0]];
   end

endmodule

### rtl/tlpp_checker.sv
// ----------------------------------------------------------------------------
// tlpp_checker
// port-level checks of the tournament predictor, bound to the top level
// ----------------------------------------------------------------------------
`include "tournament_local_perceptron_predictor_core_assert.svh"

module tlpp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a stalled response holds
   `TLPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TLPP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // one transaction in flight
   `TLPP_ASSERT_NEXT(a_one_inflight, clock, reset, req_tvalid && req_tready, !req_tready)
   // a fresh response traces back to an accepted request
   `TLPP_ASSERT(a_rsp_origin, clock, reset,
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))

endmodule

bind tournament_local_perceptron_predictor_core tlpp_checker u_tlpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/tb_tournament_local_perceptron_predictor_core.sv
// ----------------------------------------------------------------------------
// tb_tournament_local_perceptron_predictor_core
// drives predict and train transactions through the tournament predictor,
// mirrors its tables and history in a behavioral model and checks every
// prediction, with random stalls on both channels and threshold changes
// ----------------------------------------------------------------------------
module tb_tournament_local_perceptron_predictor_core;
   import tlpp_pkg::*;

   localparam int LB = LOCAL_BITS_DEF;
   localparam int CB = CHOOSER_BITS_DEF;
   localparam int RB = PERCEPTRON_ROW_BITS_DEF;
   localparam int HL = HISTORY_LEN_DEF;
   localparam int WB = WEIGHT_BITS_DEF;
   localparam int WMAX = (1 << (WB - 1)) - 1;
   // idle cycles tolerated; covers the clearing pass after reset
   localparam int IDLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic req_tuser = OP_PREDICT;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [THR_BITS-1:0] csr_wdata = '0;

   tournament_local_perceptron_predictor_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   // shadow copy of the predictor state
   logic [LB-1:0] m_lhist [0:(1<<LB)-1];
   ctr_type m_lctr [0:(1<<LB)-1];
   ctr_type m_chooser [0:(1<<CB)-1];
   int m_wt [0:(1<<RB)-1][0:HL-1];
   logic [HL-1:0] m_ghist;
   logic [THR_BITS-1:0] m_thr;

   logic pred_queue[$];
   int errors = 0;
   bit hold_rsp = 0;

   typedef struct {
      logic op;
      logic [31:0] pc;
      logic tk;
      int exp_pred; // -1 when left to the model
   } dir_row_type;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic ctr_type sat_ctr(ctr_type c, logic up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
   endfunction

   // computes the chosen prediction and applies training to the shadow state
   function automatic logic predict_and_train(logic op, logic [31:0] pc, logic tk);
      logic [LB-1:0] li;
      logic [LB-1:0] lh;
      logic [RB-1:0] row;
      logic [CB-1:0] ci;
      logic lp;
      logic gp;
      logic res;
      longint y;
      li = pc[LB-1:0];
      lh = m_lhist[li];
      lp = m_lctr[lh] >= 2;
      row = pc[RB-1:0];
      ci = m_ghist[CB-1:0];
      y = 0;
      for (int i = 0; i < HL; i++)
         if (m_ghist[i]) y += m_wt[row][HL-1-i];
      gp = y > 0;
      res = (m_chooser[ci] >= 2) ? lp : gp;
      if (op == OP_TRAIN) begin
         if (lp == tk && gp != tk) m_chooser[ci] = sat_ctr(m_chooser[ci], 1'b1);
         else if (gp == tk && lp != tk) m_chooser[ci] = sat_ctr(m_chooser[ci], 1'b0);
         if (((y < 0) != !tk) || (y < longint'(m_thr) && y > -longint'(m_thr))) begin
            for (int i = 0; i < HL; i++) begin
               if (m_ghist[i]) begin
                  if (tk && m_wt[row][HL-1-i] < WMAX) m_wt[row][HL-1-i]++;
                  if (!tk && m_wt[row][HL-1-i] > -WMAX) m_wt[row][HL-1-i]--;
               end
            end
         end
         m_lctr[lh] = sat_ctr(m_lctr[lh], tk);
         m_ghist = {m_ghist[HL-2:0], tk};
         m_lhist[li] = {lh[LB-2:0], tk};
      end
      return res;
   endfunction

   // one transaction on the request channel, after a random gap;
   // valid stays high afterwards unless a gap or a drain follows
   task automatic send_branch(logic op, logic [31:0] pc, logic tk, int exp_pred);
      logic p;
      int gap;
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, tk, pc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_and_train(op, pc, tk);
      // directed rows with a typed value are checked against that value
      pred_queue.push_back((exp_pred >= 0) ? exp_pred[0] : p);
   endtask

   // drops valid and waits until every expected result has come
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pred_queue.size() != 0) @(posedge clock);
   endtask

   // waits for all results plus a settling margin, then writes the threshold
   task automatic set_threshold(logic [THR_BITS-1:0] v);
      drain();
      repeat (6) @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      m_thr = v;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         repeat (stall) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         // rsp transaction happened at this edge
         if (pred_queue.size() == 0) begin
            $error("unexpected transaction on response channel");
            errors++;
         end else begin
            logic e;
            e = pred_queue.pop_front();
            if (rsp_tdata[0] !== e) begin
               $error("predict_taken: expected %0d actual %0d", e, rsp_tdata[0]);
               errors++;
            end
         end
         rsp_tready <= 1'b0;
      end
   end

   // watchdog on cycles without any accepted transaction
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      logic [31:0] hot_pc [0:7];
      logic [31:0] pc;
      int n;
      logic op;
      logic tk;

      for (int i = 0; i < (1<<LB); i++) begin
         m_lhist[i] = '0;
         m_lctr[i] = CTR_WEAK_TAKEN;
      end
      for (int i = 0; i < (1<<CB); i++) m_chooser[i] = CTR_STRONG_GLOBAL;
      for (int r = 0; r < (1<<RB); r++)
         for (int i = 0; i < HL; i++) m_wt[r][i] = 0;
      m_ghist = '0;
      m_thr = THR_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: after reset the chooser picks global and the sum is zero,
      // so the first prediction is not taken; extremes of pc, taken ignored
      // on predict, training both ways
      dir_rows = '{
         '{OP_PREDICT, 32'h0000_0000, 1'b0, 0},
         '{OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 0},
         '{OP_TRAIN,   32'h0000_0000, 1'b1, 0},
         '{OP_TRAIN,   32'hFFFF_FFFF, 1'b1, -1},
         '{OP_TRAIN,   32'hFFFF_FFFF, 1'b0, -1},
         '{OP_PREDICT, 32'hAAAA_AAAA, 1'b1, -1},
         '{OP_TRAIN,   32'h5555_5555, 1'b1, -1},
         '{OP_TRAIN,   32'h8000_0000, 1'b0, -1},
         '{OP_TRAIN,   32'h0000_0001, 1'b1, -1},
         '{OP_PREDICT, 32'h0000_0001, 1'b0, -1}
      };
      foreach (dir_rows[k])
         send_branch(dir_rows[k].op, dir_rows[k].pc, dir_rows[k].tk, dir_rows[k].exp_pred);
      // repeated training: one branch trained taken many times
      for (int k = 0; k < 14; k++) send_branch(OP_TRAIN, 32'h0000_0123, 1'b1, -1);

      // threshold zero: only sign disagreement trains
      set_threshold(7'd0);
      for (int k = 0; k < 300; k++) send_branch(OP_TRAIN, 32'h0000_0123, 1'b1, -1);

      for (int k = 0; k < 8; k++) hot_pc[k] = $urandom;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: set_threshold(7'd127);
            1: set_threshold(7'($urandom_range(1, 126)));
            2: set_threshold(THR_RESET);
            default: set_threshold(7'd0);
         endcase
         if (ph == 1) hold_rsp = 1; // receiver holds off, block stalls input
         n = 210;
         for (int k = 0; k < n; k++) begin
            // mostly training on a small working set with repeating patterns
            if ($urandom_range(0, 9) < 8) pc = hot_pc[$urandom_range(0, 7)];
            else pc = $urandom;
            op = ($urandom_range(0, 9) < 8) ? OP_TRAIN : OP_PREDICT;
            tk = (pc[2] ^ m_ghist[0]) ^ ($urandom_range(0, 9) == 0);
            send_branch(op, pc, tk, -1);
            // sender pauses until everything has drained
            if (ph == 2 && k == 100) drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

### sim.f
+incdir+rtl
rtl/tlpp_pkg.sv
rtl/tournament_local_perceptron_predictor_core.sv
rtl/tlpp_checker.sv
tb/sv/tb_tournament_local_perceptron_predictor_core.sv
